@@ hw/rtl/matq_pkg.sv @@
// Shared types and constants of the alarm timer queue.
`timescale 1ns / 1ps
package matq_pkg;
    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [0:0] CFG_WAKE_LIMIT  = 1'd0;
    localparam logic [0:0] CFG_START_LIMIT = 1'd1;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_WAKE  = 1'b1;

    localparam logic [63:0] NO_ALARM_WAIT = 64'h0000_0000_8000_0000;
    localparam logic [31:0] SHORTEST_WAIT = 32'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  alarm_slot;
        logic [63:0] start_delay;
        logic [31:0] timer_count;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  fired_slot;
        logic [31:0] wake_delay;
        logic        last;
    } out_item_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  alarm_slot;
        logic        in_range;
        logic        arm;
        logic [63:0] due;
        logic [63:0] now;
    } cmd_t;
endpackage

@@ hw/rtl/matq_if.sv @@
// Valid/ready channel interfaces for items and configuration writes.
`timescale 1ns / 1ps
interface matq_in_if;
    logic valid;
    logic ready;
    matq_pkg::in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface matq_out_if;
    logic valid;
    logic ready;
    matq_pkg::out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface matq_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/matq_ram.sv @@
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module matq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/matq_front.sv @@
// Front end: timestamp widening, start classification, command queue entry.
`timescale 1ns / 1ps
module matq_front #(
    parameter int SLOTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    matq_in_if.sink              in_ch,
    input  logic [63:0]          start_limit,
    output logic                 cmd_valid,
    output matq_pkg::cmd_t       cmd,
    input  logic                 cmd_ready
);
    logic [31:0]    stamp_high_reg;
    logic [31:0]    previous_count_reg;
    logic [31:0]    stamp_high_next;
    logic [63:0]    now;
    logic           accept;
    logic           wrap;
    matq_pkg::cmd_t cmd_next;
    // Two-entry queue
    matq_pkg::cmd_t q_reg [2];
    logic           rd_ptr_reg;
    logic           wr_ptr_reg;
    logic [1:0]     count_reg;

    assign in_ch.ready = (count_reg != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;
    assign wrap        = (in_ch.item.timer_count < previous_count_reg);
    assign stamp_high_next = stamp_high_reg + {31'd0, wrap};
    assign now         = {stamp_high_next, in_ch.item.timer_count};

    always_comb
    begin
        cmd_next.func       = in_ch.item.func;
        cmd_next.alarm_slot = in_ch.item.alarm_slot;
        cmd_next.in_range   = ({28'd0, in_ch.item.alarm_slot} < SLOTS);
        cmd_next.arm        = (in_ch.item.start_delay < start_limit);
        cmd_next.due        = now + in_ch.item.start_delay;
        cmd_next.now        = now;
    end

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_high_reg     <= '0;
            previous_count_reg <= '0;
            rd_ptr_reg         <= 1'b0;
            wr_ptr_reg         <= 1'b0;
            count_reg          <= '0;
        end
        else
        begin
            if (accept)
            begin
                stamp_high_reg     <= stamp_high_next;
                previous_count_reg <= in_ch.item.timer_count;
                wr_ptr_reg         <= ~wr_ptr_reg;
            end
            if (cmd_valid && cmd_ready)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, accept} - {1'b0, cmd_valid && cmd_ready};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cmd_next;
        end
    end
endmodule

@@ hw/rtl/matq_back.sv @@
// Back end: slot store, scan for fired and earliest slots, result output.
`timescale 1ns / 1ps
module matq_back #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  matq_pkg::cmd_t     cmd,
    output logic               cmd_ready,
    input  logic [31:0]        wake_limit,
    matq_out_if.source         out_ch
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_LAST, S_FIRE, S_WAKE, S_OUT
    } state_t;

    state_t          state_reg;
    matq_pkg::cmd_t  cur_reg;
    logic [SLOTS-1:0] armed_reg;
    logic [31:0]     seq_reg;
    logic [63:0]     next_wake_reg;
    logic [CW-1:0]   idx_reg;
    logic [SW-1:0]   idx_d_reg;
    logic            rd_valid_reg;
    logic            fire_found_reg;
    logic [SW-1:0]   fire_pick_reg;
    logic [63:0]     fire_due_reg;
    logic [31:0]     fire_ord_reg;
    logic            any_found_reg;
    logic [63:0]     any_due_reg;
    logic [31:0]     any_ord_reg;
    logic            out_valid_reg;
    matq_pkg::out_item_t out_reg;

    logic            we;
    logic [SW-1:0]   waddr;
    logic [SW-1:0]   raddr;
    logic [63:0]     due_rd;
    logic [31:0]     ord_rd;
    logic            cand_fire;
    logic            better_fire;
    logic            better_any;
    logic [63:0]     target;
    logic [63:0]     diff;
    logic [31:0]     delay;

    assign we    = (state_reg == S_IDLE) && cmd_valid && cmd.func == matq_pkg::FUNC_START
                   && cmd.in_range && cmd.arm;
    assign waddr = cmd.alarm_slot[SW-1:0];
    assign raddr = idx_reg[SW-1:0];

    matq_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_due (
        .clk(clk), .we(we), .waddr(waddr), .wdata(cmd.due), .raddr(raddr), .rdata(due_rd)
    );
    matq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_ord (
        .clk(clk), .we(we), .waddr(waddr), .wdata(seq_reg), .raddr(raddr), .rdata(ord_rd)
    );

    assign cand_fire   = armed_reg[idx_d_reg] && (due_rd <= cur_reg.now);
    assign better_fire = !fire_found_reg || (due_rd < fire_due_reg)
                         || (due_rd == fire_due_reg && ord_rd < fire_ord_reg);
    assign better_any  = !any_found_reg || (due_rd < any_due_reg)
                         || (due_rd == any_due_reg && ord_rd < any_ord_reg);

    // Wake delay: clamp to the register, then raise to the floor.
    always_comb
    begin
        target = (state_reg == S_IDLE) ? cmd.due
               : (any_found_reg ? any_due_reg : cur_reg.now + matq_pkg::NO_ALARM_WAIT);
        diff   = (target > ((state_reg == S_IDLE) ? cmd.now : cur_reg.now))
               ? target - ((state_reg == S_IDLE) ? cmd.now : cur_reg.now) : 64'd0;
        delay  = (diff > {32'd0, wake_limit}) ? wake_limit : diff[31:0];
        if (delay < matq_pkg::SHORTEST_WAIT)
        begin
            delay = matq_pkg::SHORTEST_WAIT;
        end
    end

    assign cmd_ready    = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            armed_reg      <= '0;
            seq_reg        <= '0;
            next_wake_reg  <= '1;
            idx_reg        <= '0;
            idx_d_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            fire_found_reg <= 1'b0;
            any_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            cur_reg        <= '0;
            fire_pick_reg  <= '0;
            fire_due_reg   <= '0;
            fire_ord_reg   <= '0;
            any_due_reg    <= '0;
            any_ord_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        cur_reg <= cmd;
                        case (cmd.func)
                            matq_pkg::FUNC_START:
                            begin
                                if (cmd.in_range)
                                begin
                                    armed_reg[waddr] <= cmd.arm;
                                    if (cmd.arm)
                                    begin
                                        seq_reg <= seq_reg + 32'd1;
                                        if (cmd.due <= next_wake_reg)
                                        begin
                                            next_wake_reg  <= cmd.now + {32'd0, delay};
                                            out_reg        <= '{matq_pkg::KIND_WAKE, 4'd0,
                                                                delay, 1'b1};
                                            out_valid_reg  <= 1'b1;
                                        end
                                    end
                                end
                            end
                            matq_pkg::FUNC_CANCEL:
                            begin
                                if (cmd.in_range)
                                begin
                                    armed_reg[waddr] <= 1'b0;
                                end
                            end
                            matq_pkg::FUNC_TICK:
                            begin
                                idx_reg        <= '0;
                                rd_valid_reg   <= 1'b0;
                                fire_found_reg <= 1'b0;
                                any_found_reg  <= 1'b0;
                                state_reg      <= S_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    // One slot read a cycle; compare the previous read.
                    if (rd_valid_reg && armed_reg[idx_d_reg])
                    begin
                        if (cand_fire && better_fire)
                        begin
                            fire_found_reg <= 1'b1;
                            fire_pick_reg  <= idx_d_reg;
                            fire_due_reg   <= due_rd;
                            fire_ord_reg   <= ord_rd;
                        end
                        if (!cand_fire && better_any)
                        begin
                            any_found_reg <= 1'b1;
                            any_due_reg   <= due_rd;
                            any_ord_reg   <= ord_rd;
                        end
                    end
                    idx_d_reg    <= idx_reg[SW-1:0];
                    if (idx_reg == CW'(SLOTS))
                    begin
                        rd_valid_reg <= 1'b0;
                        state_reg    <= S_LAST;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b1;
                        idx_reg      <= idx_reg + CW'(1);
                    end
                end
                S_LAST:
                begin
                    state_reg <= fire_found_reg ? S_FIRE : S_WAKE;
                end
                S_FIRE:
                begin
                    if (!out_valid_reg)
                    begin
                        armed_reg[fire_pick_reg] <= 1'b0;
                        out_reg        <= '{matq_pkg::KIND_FIRED, 4'(fire_pick_reg), 32'd0, 1'b0};
                        out_valid_reg  <= 1'b1;
                        // Rescan for the next fired slot.
                        idx_reg        <= '0;
                        rd_valid_reg   <= 1'b0;
                        fire_found_reg <= 1'b0;
                        any_found_reg  <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_WAKE:
                begin
                    if (!out_valid_reg)
                    begin
                        next_wake_reg <= cur_reg.now + {32'd0, delay};
                        out_reg       <= '{matq_pkg::KIND_WAKE, 4'd0, delay, 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ hw/rtl/multi_alarm_timer_queue_top.sv @@
// Top level of the multi-alarm timer queue.
// A start's wake item passes through the front end queue and is then registered in the back end;
// start and cancel are handled in the back end's idle state, and the front end queues up to two items ahead of it.
// A tick scans the slot store once per fired slot and once more, and its last item is the
// wake item issued after that final scan.
// Reset clears armed flags, timestamp and counters; slot store needs no clearing.
`timescale 1ns / 1ps
module multi_alarm_timer_queue_top #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    matq_in_if.sink     in_ch,
    matq_out_if.source  out_ch,
    matq_cfg_if.sink    cfg
);
    logic [31:0]    wake_limit_reg;
    logic [63:0]    start_limit_reg;
    logic           cmd_valid;
    logic           cmd_ready;
    matq_pkg::cmd_t cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_limit_reg  <= 32'hFFFF_FFFF;
            start_limit_reg <= 64'h8000_0000_0000_0000;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                matq_pkg::CFG_WAKE_LIMIT:  wake_limit_reg  <= cfg.data[31:0];
                matq_pkg::CFG_START_LIMIT: start_limit_reg <= cfg.data;
                default:                   wake_limit_reg  <= wake_limit_reg;
            endcase
        end
    end

    matq_front #(.SLOTS(SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .start_limit(start_limit_reg),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
    );

    matq_back #(.SLOTS(SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_ready(cmd_ready), .wake_limit(wake_limit_reg), .out_ch(out_ch)
    );
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the multi-alarm timer queue: directed and random items.
`timescale 1ns / 1ps
module testbench;
    localparam int NSLOTS = 16;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    class alarm_scoreboard;
        logic [31:0] wake_limit;
        logic [63:0] delay_limit;
        logic [31:0] stamp_hi;
        logic [31:0] prev_count;
        logic [63:0] wake_time;
        logic [63:0] due_time [NSLOTS];
        bit          armed [NSLOTS];
        logic [31:0] order [NSLOTS];
        logic [31:0] seq;
        matq_pkg::out_item_t pending [$];
        int          mismatches;
        int          checked;
        int          fired_count;

        function void clear();
            wake_limit = 32'hFFFF_FFFF;
            delay_limit = 64'h8000_0000_0000_0000;
            stamp_hi = '0;
            prev_count = '0;
            wake_time = '1;
            seq = '0;
            for (int i = 0; i < NSLOTS; i++)
            begin
                armed[i] = 0;
                due_time[i] = '0;
                order[i] = '0;
            end
            pending.delete();
            mismatches = 0;
            checked = 0;
            fired_count = 0;
        endfunction

        function void write_reg(logic idx, logic [63:0] val);
            if (idx == matq_pkg::CFG_WAKE_LIMIT)
                wake_limit = val[31:0];
            else
                delay_limit = val;
        endfunction

        function bit sooner(int a, int b);
            if (due_time[a] != due_time[b])
                return due_time[a] < due_time[b];
            return order[a] < order[b];
        endfunction

        function logic [31:0] wake_for(logic [63:0] due, logic [63:0] now);
            logic [63:0] d;
            d = (due > now) ? due - now : 64'd0;
            if (d > {32'd0, wake_limit})
                d = {32'd0, wake_limit};
            if (d < 64'd2)
                d = 64'd2;
            wake_time = now + d;
            return d[31:0];
        endfunction

        function void push(logic k, logic [3:0] s, logic [31:0] w, logic l);
            matq_pkg::out_item_t r;
            r.kind = k;
            r.fired_slot = s;
            r.wake_delay = w;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void note_input(matq_pkg::in_item_t it);
            logic [63:0] now;
            logic [63:0] due;
            int pick;
            if (it.timer_count < prev_count)
                stamp_hi = stamp_hi + 32'd1;
            prev_count = it.timer_count;
            now = {stamp_hi, it.timer_count};
            case (it.func)
                matq_pkg::FUNC_START:
                begin
                    armed[it.alarm_slot] = 0;
                    if (it.start_delay < delay_limit)
                    begin
                        due = now + it.start_delay;
                        due_time[it.alarm_slot] = due;
                        order[it.alarm_slot] = seq;
                        seq = seq + 32'd1;
                        armed[it.alarm_slot] = 1;
                        if (due <= wake_time)
                            push(matq_pkg::KIND_WAKE, 4'd0, wake_for(due, now), 1'b1);
                    end
                end
                matq_pkg::FUNC_CANCEL: armed[it.alarm_slot] = 0;
                matq_pkg::FUNC_TICK:
                begin
                    forever
                    begin
                        pick = -1;
                        for (int i = 0; i < NSLOTS; i++)
                            if (armed[i] && due_time[i] <= now && (pick < 0 || sooner(i, pick)))
                                pick = i;
                        if (pick < 0)
                            break;
                        armed[pick] = 0;
                        fired_count++;
                        push(matq_pkg::KIND_FIRED, pick[3:0], 32'd0, 1'b0);
                    end
                    pick = -1;
                    for (int i = 0; i < NSLOTS; i++)
                        if (armed[i] && (pick < 0 || sooner(i, pick)))
                            pick = i;
                    due = (pick >= 0) ? due_time[pick] : now + matq_pkg::NO_ALARM_WAIT;
                    push(matq_pkg::KIND_WAKE, 4'd0, wake_for(due, now), 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(matq_pkg::out_item_t got);
            matq_pkg::out_item_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.fired_slot !== want.fired_slot ||
                got.wake_delay !== want.wake_delay || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    matq_in_if  in_ch();
    matq_out_if out_ch();
    matq_cfg_if cfg();

    multi_alarm_timer_queue_top #(.SLOTS(NSLOTS)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
    );

    always #10 clk = ~clk;

    alarm_scoreboard sb;
    logic [31:0] count_now;
    int          burst_left;
    bit          hold_long;
    bit          stall_free;
    int          items_sent;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.item = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = 1'b0;
        cfg.data = '0;
    end

    // Sink side: stall pattern, with occasional long hold-off.
    initial
    begin
        int phase;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.item);
            phase++;
            if (hold_long)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk)
                    if (out_ch.valid && out_ch.ready)
                        sb.check_result(out_ch.item);
                hold_long = 0;
                out_ch.ready <= 1'b1;
            end
            else if (stall_free || (phase % 64) < 20)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic idx, logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Stop offering items and wait until every expected result has come.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4 * (NSLOTS + 3) + 10) @(posedge clk);
    endtask

    task automatic send(logic [1:0] f, logic [3:0] s, logic [63:0] d, logic [31:0] adv);
        matq_pkg::in_item_t it;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        count_now = count_now + adv;
        it.func = f;
        it.alarm_slot = s;
        it.start_delay = d;
        it.timer_count = count_now;
        in_ch.valid <= 1'b1;
        in_ch.item <= it;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        logic [63:0] d;
        logic [31:0] adv;
        logic [3:0] s;
        r = $urandom_range(0, 99);
        s = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0: d = {$urandom, $urandom};
            1: d = {32'd0, $urandom_range(0, 3)};
            default: d = {32'd0, $urandom_range(0, 4000)};
        endcase
        adv = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 600);
        if (r < 50)
            send(matq_pkg::FUNC_START, s, d, adv);
        else if (r < 62)
            send(matq_pkg::FUNC_CANCEL, s, d, adv);
        else if (r < 97)
            send(matq_pkg::FUNC_TICK, s, d, adv);
        else
            send(FUNC_UNUSED, s, d, adv);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        count_now = 0;
        burst_left = 0;
        hold_long = 0;
        stall_free = 0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, ties, wrap, unused code.
        write_reg(matq_pkg::CFG_WAKE_LIMIT, 64'd1);
        write_reg(matq_pkg::CFG_START_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
        stall_free = 1;
        send(matq_pkg::FUNC_TICK, 4'd0, '0, 32'd0);
        send(matq_pkg::FUNC_START, 4'd15, 64'hFFFF_FFFF_FFFF_FFFE, 32'd5);
        send(matq_pkg::FUNC_START, 4'd0, 64'd0, 32'd0);
        send(matq_pkg::FUNC_START, 4'd3, 64'd10, 32'd0);
        send(matq_pkg::FUNC_START, 4'd4, 64'd10, 32'd0);
        send(matq_pkg::FUNC_TICK, 4'd0, '0, 32'd20);
        send(matq_pkg::FUNC_CANCEL, 4'd15, '0, 32'd0);
        send(FUNC_UNUSED, 4'd15, '1, 32'd1);
        send(matq_pkg::FUNC_TICK, 4'hF, '1, 32'hFFFF_FFF0);
        send(matq_pkg::FUNC_START, 4'd7, 64'd100, 32'd0);
        send(matq_pkg::FUNC_TICK, 4'd0, '0, 32'd200);
        drain();
        write_reg(matq_pkg::CFG_WAKE_LIMIT, 64'hFFFF_FFFF);
        write_reg(matq_pkg::CFG_START_LIMIT, 64'd0);
        send(matq_pkg::FUNC_START, 4'd1, 64'd0, 32'd3);
        send(matq_pkg::FUNC_TICK, 4'd0, '0, 32'd3);
        drain();
        write_reg(matq_pkg::CFG_START_LIMIT, 64'd1000);
        write_reg(matq_pkg::CFG_WAKE_LIMIT, 64'd2);
        send(matq_pkg::FUNC_START, 4'd2, 64'd999, 32'd1);
        send(matq_pkg::FUNC_START, 4'd5, 64'd1000, 32'd1);
        send(matq_pkg::FUNC_TICK, 4'd0, '0, 32'd5000);
        send(matq_pkg::FUNC_START, 4'd2, 64'd50, 32'd0);
        send(matq_pkg::FUNC_TICK, 4'd0, '0, 32'd0);
        drain();
        stall_free = 0;

        // Random phases over several settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(matq_pkg::CFG_WAKE_LIMIT,
                      (ph == 0) ? 64'hFFFF_FFFF : {32'd0, $urandom_range(2, 3000)});
            write_reg(matq_pkg::CFG_START_LIMIT, (ph == 3) ? 64'h8000_0000_0000_0000 :
                      {32'd0, $urandom_range(500, 5000)});
            if (ph == 1)
                hold_long = 1;
            for (int n = 0; n < 75; n++)
                random_item();
            in_ch.valid <= 1'b0;
            drain();
        end
        idle_input();

        $display("Sent %0d items over several register settings; %0d results checked, %0d alarms fired.",
                 items_sent, sb.checked, sb.fired_count);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/matq_pkg.sv
hw/rtl/matq_if.sv
hw/rtl/matq_ram.sv
hw/rtl/matq_front.sv
hw/rtl/matq_back.sv
hw/rtl/multi_alarm_timer_queue_top.sv
bench/testbench.sv
